/* hw/rtl/arss_pkg.sv */
// ----------------------------------------------------------------------------
// arss_pkg
// Shared types, constants and helpers for the ARMA state-space filter core.
// ----------------------------------------------------------------------------
package arss_pkg;

	// Fixed-point format of the coefficients (Q2.14).
	localparam int Q_SHIFT     = 14;
	localparam int SAMPLE_W    = 16;
	localparam int COEF_W      = 16;
	localparam int BURN_W      = 8;
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 16;

	// Widest product of two 16-bit signed operands, plus the rounding constant.
	localparam int PRE_W = 32;
	// Floor of a 33-bit accumulator shifted down by Q_SHIFT.
	localparam int SHIFTED_W = PRE_W + 1 - Q_SHIFT;
	// Shifted value plus one 16-bit neighbour.
	localparam int SUM_W = SHIFTED_W + 1;

	localparam logic signed [PRE_W-1:0] ROUND_HALF = PRE_W'(1 << (Q_SHIFT - 1));

	// Number of coefficient slots the register map provides.
	localparam int MAX_AR = 4;
	localparam int MAX_MA = 3;

	// Default filter order and queue size.
	localparam int STATE_DIM_DEF = 4;
	localparam int QUEUE_DEPTH   = 2;

	// Burn-in length after reset.
	localparam logic [BURN_W-1:0] BURN_RESET = BURN_W'(50);

	// Register map indexes.
	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_AR_COEF_1     = 3'd0,
		REG_AR_COEF_2     = 3'd1,
		REG_AR_COEF_3     = 3'd2,
		REG_AR_COEF_4     = 3'd3,
		REG_MA_COEF_1     = 3'd4,
		REG_MA_COEF_2     = 3'd5,
		REG_MA_COEF_3     = 3'd6,
		REG_BURN_IN_COUNT = 3'd7
	} arss_reg_t;

	// Configuration seen by the front and back parts.
	typedef struct packed {
		logic [MAX_AR-1:0][COEF_W-1:0] ar_coef;
		logic [MAX_MA-1:0][COEF_W-1:0] ma_coef;
		logic [BURN_W-1:0]             burn_in_count;
	} arss_cfg_t;

	// Saturate a widened sum to a signed 16-bit sample.
	function automatic logic [SAMPLE_W-1:0] sat_sample(input logic signed [SUM_W-1:0] v);
		logic signed [SUM_W-1:0] max_v;
		logic signed [SUM_W-1:0] min_v;
		max_v = SUM_W'((1 << (SAMPLE_W - 1)) - 1);
		min_v = -SUM_W'(1 << (SAMPLE_W - 1));
		if (v > max_v) begin
			sat_sample = max_v[SAMPLE_W-1:0];
		end else if (v < min_v) begin
			sat_sample = min_v[SAMPLE_W-1:0];
		end else begin
			sat_sample = v[SAMPLE_W-1:0];
		end
	endfunction

endpackage

/* hw/rtl/arss_front.sv */
// ----------------------------------------------------------------------------
// arss_front
// Accepts noise words, forms the rounded innovation terms of every state
// element and decides whether the sample is still in the burn-in phase.
// ----------------------------------------------------------------------------
module arss_front
	import arss_pkg::*;
#(
	parameter int STATE_DIM = STATE_DIM_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  arss_cfg_t                           cfg,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [SAMPLE_W-1:0]                 noise_sample,
	input  logic                                queue_full,
	output logic                                push,
	output logic                                push_emit,
	output logic [STATE_DIM-1:0][PRE_W-1:0]     push_pre
);

	logic [BURN_W-1:0] burn_counter_q;
	logic              emit;

	assign in_ready  = !queue_full;
	assign push      = in_valid && in_ready;
	assign emit      = (burn_counter_q >= cfg.burn_in_count);
	assign push_emit = emit;

	// Burn-in counter: counts absorbed samples, holds once output starts.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			burn_counter_q <= '0;
		end else if (push && !emit) begin
			burn_counter_q <= burn_counter_q + 1'b1;
		end
	end

	// Innovation terms: theta[i]*e plus the rounding half; theta[0] is one.
	genvar i;
	generate
		for (i = 0; i < STATE_DIM; i++) begin : g_pre
			if (i == 0) begin : g_unit
				logic signed [PRE_W-1:0] scaled;
				assign scaled = {{(PRE_W - SAMPLE_W - Q_SHIFT){noise_sample[SAMPLE_W-1]}},
					noise_sample, {Q_SHIFT{1'b0}}};
				assign push_pre[i] = scaled + ROUND_HALF;
			end else begin : g_ma
				logic signed [PRE_W-1:0] prod;
				assign prod = $signed(cfg.ma_coef[i-1]) * $signed(noise_sample);
				assign push_pre[i] = prod + ROUND_HALF;
			end
		end
	endgenerate

endmodule

/* hw/rtl/arss_queue.sv */
// ----------------------------------------------------------------------------
// arss_queue
// Small register queue that decouples the front part from the back part.
// ----------------------------------------------------------------------------
module arss_queue
	import arss_pkg::*;
#(
	parameter int WIDTH = 1,
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	input  logic             pop,
	output logic [WIDTH-1:0] head_data,
	output logic             empty,
	output logic             full
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] entries_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign empty     = (count_q == '0);
	assign full      = (count_q == CNT_W'(DEPTH));
	assign head_data = entries_q[rd_ptr_q];

	// Storage is written only at the tail; no reset needed.
	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_data;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

`ifndef SYNTHESIS
	// The front part must never write into a full queue.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full))
		else $error("queue written while full");

	// The back part must never take from an empty queue.
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && empty))
		else $error("queue read while empty");

	// A push alone raises the fill count by exactly one.
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (count_q == $past(count_q) + 1'b1))
		else $error("queue fill count out of step");
`endif

endmodule

/* hw/rtl/arss_back.sv */
// ----------------------------------------------------------------------------
// arss_back
// Holds the filter state, applies the autoregressive feedback for one queued
// sample per cycle unless a stalled output holds it, and drives the output register.
// ----------------------------------------------------------------------------
module arss_back
	import arss_pkg::*;
#(
	parameter int STATE_DIM = STATE_DIM_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  arss_cfg_t                       cfg,
	input  logic                            queue_empty,
	input  logic                            head_emit,
	input  logic [STATE_DIM-1:0][PRE_W-1:0] head_pre,
	output logic                            pop,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [SAMPLE_W-1:0]             process_sample
);

	logic [STATE_DIM-1:0][SAMPLE_W-1:0] state_q;
	logic [STATE_DIM-1:0][SAMPLE_W-1:0] state_next;
	logic                               out_valid_q;
	logic [SAMPLE_W-1:0]                out_data_q;
	logic                               out_load;

	// A sample that emits needs room in the output register.
	assign pop      = !queue_empty && (!head_emit || !out_valid_q || out_ready);
	assign out_load = pop && head_emit;

	// Per-element update: phi[i]*x0 plus the queued term, floored, plus neighbour.
	genvar i;
	generate
		for (i = 0; i < STATE_DIM; i++) begin : g_elem
			logic signed [PRE_W-1:0]     prod;
			logic signed [PRE_W:0]       acc;
			logic signed [SHIFTED_W-1:0] shifted;
			logic signed [SUM_W-1:0]     total;

			assign prod    = $signed(cfg.ar_coef[i]) * $signed(state_q[0]);
			assign acc     = {prod[PRE_W-1], prod} + {head_pre[i][PRE_W-1], head_pre[i]};
			assign shifted = acc[PRE_W:Q_SHIFT];

			if (i + 1 < STATE_DIM) begin : g_nbr
				assign total = {shifted[SHIFTED_W-1], shifted}
					+ {{(SUM_W - SAMPLE_W){state_q[i+1][SAMPLE_W-1]}}, state_q[i+1]};
			end else begin : g_last
				assign total = {shifted[SHIFTED_W-1], shifted};
			end

			assign state_next[i] = sat_sample(total);
		end
	endgenerate

	// Filter state advances once per dequeued sample.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (pop) begin
			state_q <= state_next;
		end
	end

	// Output register: loads the new first element, clears when taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_data_q <= state_next[0];
		end
	end

	assign out_valid      = out_valid_q;
	assign process_sample = out_data_q;

endmodule

/* hw/rtl/arma_state_space_filter_core.sv */
// ----------------------------------------------------------------------------
// arma_state_space_filter_core
// ARMA process generator in transposed direct form with burn-in gating.
//
//   channel  direction  word contents
//   s_axis   in         tdata[15:0] noise_sample (signed)
//   m_axis   out        tdata[15:0] process_sample (signed, saturated)
//   cfg      in         cfg_index selects register, cfg_wdata[15:0] value
//
// One sample is accepted per cycle while the queue has room. Each sample is
// first held in the queue; then the feedback multiply and saturation load
// its result word into the output register.
// Burn-in samples update the state and produce no word.
// Reset clears the state, the burn-in counter and the coefficients and loads
// a burn-in length of 50; no clearing pass is needed.
// A stalled output holds the back part; a two-entry queue keeps the input
// side accepting until it fills.
// ----------------------------------------------------------------------------
module arma_state_space_filter_core
	import arss_pkg::*;
#(
	parameter int STATE_DIM = STATE_DIM_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// Input stream. tdata: [15:0] noise_sample
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [SAMPLE_W-1:0]    s_axis_tdata,
	// Output stream. tdata: [15:0] process_sample
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	output logic [SAMPLE_W-1:0]    m_axis_tdata,
	// Configuration write port.
	input  logic                   cfg_wen,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

	localparam int ENTRY_W = STATE_DIM * PRE_W + 1;

	arss_cfg_t                        cfg_q;
	logic                             push;
	logic                             push_emit;
	logic [STATE_DIM-1:0][PRE_W-1:0]  push_pre;
	logic                             pop;
	logic                             queue_empty;
	logic                             queue_full;
	logic [ENTRY_W-1:0]               head_data;
	logic                             head_emit;
	logic [STATE_DIM-1:0][PRE_W-1:0]  head_pre;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.ar_coef       <= '0;
			cfg_q.ma_coef       <= '0;
			cfg_q.burn_in_count <= BURN_RESET;
		end else if (cfg_wen) begin
			case (arss_reg_t'(cfg_index))
				REG_AR_COEF_1:     cfg_q.ar_coef[0]    <= cfg_wdata;
				REG_AR_COEF_2:     cfg_q.ar_coef[1]    <= cfg_wdata;
				REG_AR_COEF_3:     cfg_q.ar_coef[2]    <= cfg_wdata;
				REG_AR_COEF_4:     cfg_q.ar_coef[3]    <= cfg_wdata;
				REG_MA_COEF_1:     cfg_q.ma_coef[0]    <= cfg_wdata;
				REG_MA_COEF_2:     cfg_q.ma_coef[1]    <= cfg_wdata;
				REG_MA_COEF_3:     cfg_q.ma_coef[2]    <= cfg_wdata;
				REG_BURN_IN_COUNT: cfg_q.burn_in_count <= cfg_wdata[BURN_W-1:0];
				default: ;
			endcase
		end
	end

	// Front part: accept and classify.
	arss_front #(
		.STATE_DIM (STATE_DIM)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.in_valid     (s_axis_tvalid),
		.in_ready     (s_axis_tready),
		.noise_sample (s_axis_tdata),
		.queue_full   (queue_full),
		.push         (push),
		.push_emit    (push_emit),
		.push_pre     (push_pre)
	);

	// Queue between the two parts.
	arss_queue #(
		.WIDTH (ENTRY_W),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data ({push_emit, push_pre}),
		.pop       (pop),
		.head_data (head_data),
		.empty     (queue_empty),
		.full      (queue_full)
	);

	assign head_emit = head_data[ENTRY_W-1];
	assign head_pre  = head_data[ENTRY_W-2:0];

	// Back part: state update and output.
	arss_back #(
		.STATE_DIM (STATE_DIM)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg_q),
		.queue_empty    (queue_empty),
		.head_emit      (head_emit),
		.head_pre       (head_pre),
		.pop            (pop),
		.out_valid      (m_axis_tvalid),
		.out_ready      (m_axis_tready),
		.process_sample (m_axis_tdata)
	);

endmodule
